// ===== sv/djq_pkg.sv =====
// Shared definitions for the deduplicating job queue.
// Holds request codes, the controller state type and default sizing.
// No dependencies.
package djq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int CODE_W          = 4;
	localparam int OCC_W           = 7;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_STATUS = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_SCAN,
		ST_APPEND,
		ST_RESP
	} djq_state_t;

endpackage

// ===== sv/djq_ram.sv =====
// Simple dual-port slot memory: one write port, one registered read port.
// Generic; no package dependencies.
module djq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 4,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/dedup_job_queue_unit.sv =====
// Deduplicating job queue. Jobs sit in a circular buffer in a slot memory; the head
// (job in progress) is mirrored in a register. Status goes straight to ST_RESP; a pop
// passes through ST_POP_RD first when jobs wait behind the head. An insert sweeps the
// pending entries once through the memory's single read port, copying survivors down
// through the write port, then appends. One request is in flight at a time; a finished
// result waits in the output register while the next request is taken.
// Memory contents need no clearing after reset: entries past the count are never read.
// Depends on djq_pkg and djq_ram.
module dedup_job_queue_unit
	import djq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [CODE_W-1:0] job_code,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CODE_W-1:0] head_job,
	output logic [OCC_W-1:0]  occupancy,
	output logic              duplicate_removed,
	output logic              insert_dropped,
	output logic              pop_done
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	// logical slot index -> physical address, relative to the head pointer
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] idx);
		logic [CW:0] sum;
		sum = (CW+1)'(hd) + (CW+1)'(idx);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	djq_state_t state_q, state_d;

	logic [AW-1:0]     hd_q;
	logic [CW-1:0]     cnt_q;
	logic [CODE_W-1:0] head_q;
	logic [CODE_W-1:0] code_q;
	logic [CW-1:0]     ri_q;
	logic [CW-1:0]     wi_q;
	logic              rd_vld_s1;
	logic              dup_q, drop_q, pop_q;
	logic              out_vld_q;

	logic              accept;
	logic              scan_issue;
	logic              out_load;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CODE_W-1:0] ram_wdata, ram_rdata;

	djq_ram #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(CODE_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign scan_issue = (state_q == ST_SCAN) && (ri_q < cnt_q);
	assign out_load   = (state_q == ST_RESP) && (!out_vld_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = phys(hd_q, ONE_C);
		ram_we    = 1'b0;
		ram_waddr = phys(hd_q, wi_q);
		ram_wdata = code_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_INSERT: begin
							if (job_code == '0) begin
								state_d = ST_RESP;
							end else if (cnt_q > ONE_C) begin
								state_d = ST_SCAN;
							end else begin
								state_d = ST_APPEND;
							end
						end
						REQ_POP: begin
							if (cnt_q > ONE_C) begin
								ram_re  = 1'b1;
								state_d = ST_POP_RD;
							end else begin
								state_d = ST_RESP;
							end
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_POP_RD: state_d = ST_RESP;
			ST_SCAN: begin
				ram_re    = scan_issue;
				ram_raddr = phys(hd_q, ri_q);
				// survivors are copied down to the write index
				if (rd_vld_s1 && ram_rdata != code_q) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
				end
				if (!scan_issue && !rd_vld_s1) begin
					state_d = ST_APPEND;
				end
			end
			ST_APPEND: begin
				ram_we  = (wi_q != DEPTH_C);
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_q      <= '0;
			cnt_q     <= '0;
			head_q    <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (state_q == ST_IDLE && accept && req_type == REQ_POP && cnt_q != '0) begin
				hd_q  <= phys(hd_q, ONE_C);
				cnt_q <= cnt_q - ONE_C;
			end
			if (state_q == ST_POP_RD) begin
				head_q <= ram_rdata;
			end
			if (state_q == ST_APPEND) begin
				if (wi_q != DEPTH_C) begin
					cnt_q <= wi_q + ONE_C;
					if (wi_q == '0) begin
						head_q <= code_q;
					end
				end else begin
					cnt_q <= wi_q;
				end
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// per-request working registers and the result outputs
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= job_code;
			ri_q   <= ONE_C;
			wi_q   <= (cnt_q == '0) ? '0 : ONE_C;
			dup_q  <= 1'b0;
			drop_q <= 1'b0;
			pop_q  <= (req_type == REQ_POP) && (cnt_q != '0);
		end
		if (scan_issue) begin
			ri_q <= ri_q + ONE_C;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (ram_rdata == code_q) begin
				dup_q <= 1'b1;
			end else begin
				wi_q <= wi_q + ONE_C;
			end
		end
		if (state_q == ST_APPEND && wi_q == DEPTH_C) begin
			drop_q <= 1'b1;
		end
		if (out_load) begin
			head_job          <= (cnt_q != '0) ? head_q : '0;
			occupancy         <= OCC_W'(cnt_q);
			duplicate_removed <= dup_q;
			insert_dropped    <= drop_q;
			pop_done          <= pop_q;
		end
	end

	assign out_valid = out_vld_q;

endmodule

// ===== sv/djq_checker.sv =====
// Port-level checks for the deduplicating job queue, bound to the top level.
// Depends on djq_pkg for field widths.
module djq_checker
	import djq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [1:0]        req_type,
	input logic [CODE_W-1:0] job_code,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CODE_W-1:0] head_job,
	input logic [OCC_W-1:0]  occupancy,
	input logic              duplicate_removed,
	input logic              insert_dropped,
	input logic              pop_done
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(head_job) && $stable(occupancy))
		else $error("stalled result changed");

	// head is empty exactly when the queue is empty
	a_head_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((occupancy == '0) == (head_job == '0)))
		else $error("head and occupancy disagree");

	// at most one flag per result
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({duplicate_removed, insert_dropped, pop_done}))
		else $error("conflicting flags");

	// one request at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer while busy");

endmodule

bind dedup_job_queue_unit djq_checker u_djq_checker (.*);
